FILE: design/aglmg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aglmg_pkg
// shared types and constants of the audio gain, level meter and gate block
// ----------------------------------------------------------------------------
package aglmg_pkg;

    localparam int unsigned BLOCK_MAX_DEF  = 2048;
    localparam int unsigned COUNT_BITS_DEF = 32;

    localparam logic [12:0] GAIN_MIN   = 13'd64;
    localparam logic [12:0] GAIN_MAX   = 13'd4096;
    localparam logic [12:0] GAIN_RESET = 13'd1024;

    localparam logic [1:0] REG_GAIN = 2'd0;
    localparam logic [1:0] REG_THR  = 2'd1;
    localparam logic [1:0] REG_HYST = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_GMUL1,
        ST_GMUL2,
        ST_GATE,
        ST_DIV,
        ST_SQRT,
        ST_DONE,
        ST_OUT
    } state_t;

endpackage

FILE: design/audio_gain_level_meter_gate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_gain_level_meter_gate
// q8 gain with saturation, peak and rms metering, silence gate with hysteresis
// ----------------------------------------------------------------------------
// channel   dir  signals                         contents
// s_axis    in   s_tvalid s_tready s_tdata s_tuser sample, block end, start
// m_axis    out  m_tvalid m_tready m_tdata m_tuser gained word and statistics
// apb       in   psel penable pwrite paddr pwdata  gain, threshold, hysteresis
//
// a word that does not close a block passes ST_MUL, ST_ACC, ST_GMUL1,
// ST_GMUL2, ST_DONE and ST_OUT into the output register; a closing word
// also passes ST_GATE, restoring divider (64 by COUNT_BITS), bit-serial root.
// s_tready is low from acceptance until the result word is loaded into the
// output register; a word still waiting there holds back only the next load.
// reset is synchronous, active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
module audio_gain_level_meter_gate import aglmg_pkg::*; #(
    parameter int unsigned BLOCK_MAX  = BLOCK_MAX_DEF,
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample_in
    input  logic [1:0]  s_tuser,   // block_end, start_new
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // scaled_out, clipped_so_far, peak_level,
                                   // gate_open, gated_count, total_rms, pad
    output logic        m_tuser,   // stats_valid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int BCW = $clog2(BLOCK_MAX + 1);
    localparam int CW  = COUNT_BITS;
    localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};
    localparam logic [32:0] ACTIVE_MAX = (CW >= 32) ? 33'h0ffffffff
                                                     : 33'((64'd1 << CW) - 1);
    localparam int BSW = 32 + BCW;

    state_t state_reg, state_next;

    logic [12:0] gain_reg;
    logic [14:0] thr_reg, hyst_reg;

    logic [63:0]      tsum_reg, tsum_next;
    logic [CW-1:0]    tcnt_reg, tcnt_next;
    logic [BSW-1:0]   bsum_reg, bsum_next;
    logic [BCW-1:0]   bcnt_reg, bcnt_next;
    logic [14:0]      peak_reg, peak_next;
    logic             clip_reg, clip_next;
    logic             gate_reg, gate_next;
    logic [31:0]      act_reg, act_next;
    logic [15:0]      rms_reg, rms_next;

    logic [15:0] samp_reg, samp_next;
    logic        bend_reg, bend_next;
    logic        close_reg, close_next;
    logic signed [31:0] prod_reg, prod_next;
    logic [15:0] g_reg, g_next;
    logic [31:0] sq_reg, sq_next;
    logic [63:0] work_reg, work_next;   // divider quotient / sqrt radicand
    logic [CW:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] lvl_reg, lvl_next;
    logic        mvalid_reg, mvalid_next;
    logic [87:0] mdata_reg, mdata_next;
    logic        muser_reg, muser_next;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic wr_en;
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            REG_GAIN: prdata = {19'd0, gain_reg};
            REG_THR:  prdata = {17'd0, thr_reg};
            REG_HYST: prdata = {17'd0, hyst_reg};
            default:  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RESET;
            thr_reg  <= '0;
            hyst_reg <= '0;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_GAIN: begin
                    if (pwdata[12:0] < GAIN_MIN)      gain_reg <= GAIN_MIN;
                    else if (pwdata[12:0] > GAIN_MAX) gain_reg <= GAIN_MAX;
                    else                              gain_reg <= pwdata[12:0];
                end
                REG_THR:  thr_reg  <= pwdata[14:0];
                REG_HYST: hyst_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    logic signed [31:0] qt;
    logic [15:0]        mag;
    logic [BSW-1:0]     bsum_acc;
    logic [BCW-1:0]     bcnt_acc;
    logic [64:0]        tsum_add;
    logic [CW:0]        rem_sh;
    logic [63:0]        sq_trial;
    logic [14:0]        lvl15;
    logic [32:0]        act_add;

    always_comb begin
        state_next  = state_reg;
        tsum_next   = tsum_reg;
        tcnt_next   = tcnt_reg;
        bsum_next   = bsum_reg;
        bcnt_next   = bcnt_reg;
        peak_next   = peak_reg;
        clip_next   = clip_reg;
        gate_next   = gate_reg;
        act_next    = act_reg;
        rms_next    = rms_reg;
        samp_next   = samp_reg;
        bend_next   = bend_reg;
        close_next  = close_reg;
        prod_next   = prod_reg;
        g_next      = g_reg;
        sq_next     = sq_reg;
        work_next   = work_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        cnt_next    = cnt_reg;
        lvl_next    = lvl_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        mul_a       = 32'(signed'(samp_reg));
        mul_b       = {19'd0, gain_reg};
        s_tready    = 1'b0;
        qt          = '0;
        mag         = '0;
        bsum_acc    = '0;
        bcnt_acc    = '0;
        tsum_add    = '0;
        rem_sh      = '0;
        sq_trial    = '0;
        lvl15       = '0;
        act_add     = '0;

        if (mvalid_reg && m_tready) mvalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    samp_next = s_tdata;
                    bend_next = s_tuser[0];
                    if (s_tuser[1]) begin
                        tsum_next = '0; tcnt_next = '0; bsum_next = '0;
                        bcnt_next = '0; peak_next = '0; clip_next = 1'b0;
                        gate_next = 1'b0; act_next = '0; rms_next = '0;
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = signed'(mul_p[31:0]);
                state_next = ST_ACC;
            end
            ST_ACC: begin
                // truncate toward zero then saturate
                qt = (prod_reg + (prod_reg[31] ? 32'sd255 : 32'sd0)) >>> 8;
                if (qt > 32'sd32767) begin
                    g_next = 16'h7fff; clip_next = 1'b1;
                end else if (qt < -32'sd32768) begin
                    g_next = 16'h8000; clip_next = 1'b1;
                end else begin
                    g_next = qt[15:0];
                end
                state_next = ST_GMUL1;
            end
            ST_GMUL1: begin
                mul_a   = 32'(signed'(g_reg));
                mul_b   = 32'(signed'(g_reg));
                sq_next = mul_p[31:0];
                mag = g_reg[15] ? 16'(-signed'(g_reg)) : g_reg;
                if (mag[15]) mag = 16'h7fff;
                if (mag[14:0] > peak_reg) peak_next = mag[14:0];
                state_next = ST_GMUL2;
            end
            ST_GMUL2: begin
                bsum_acc  = bsum_reg + BSW'(sq_reg);
                bcnt_acc  = bcnt_reg + 1'b1;
                bsum_next = bsum_acc;
                bcnt_next = bcnt_acc;
                if (tcnt_reg != COUNT_MAX) begin
                    tcnt_next = tcnt_reg + 1'b1;
                    tsum_add  = {1'b0, tsum_reg} + 65'(sq_reg);
                    tsum_next = tsum_add[64] ? 64'hffffffffffffffff : tsum_add[63:0];
                end
                close_next = bend_reg || (32'(bcnt_acc) >= 32'(BLOCK_MAX));
                lvl15 = gate_reg ? ((thr_reg > hyst_reg) ? thr_reg - hyst_reg : 15'd0)
                                 : thr_reg;
                mul_a = {17'd0, lvl15};
                mul_b = {17'd0, lvl15};
                lvl_next = mul_p;
                state_next = (bend_reg || (32'(bcnt_acc) >= 32'(BLOCK_MAX)))
                           ? ST_GATE : ST_DONE;
            end
            ST_GATE: begin
                mul_a = lvl_reg[31:0];
                mul_b = 32'(bcnt_reg);
                gate_next = (thr_reg == 15'd0) || (64'(bsum_reg) >= mul_p);
                if ((thr_reg == 15'd0) || (64'(bsum_reg) >= mul_p)) begin
                    act_add  = {1'b0, act_reg} + 33'(bcnt_reg);
                    act_next = (act_add > ACTIVE_MAX) ? ACTIVE_MAX[31:0] : act_add[31:0];
                end
                work_next  = tsum_reg;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // restoring divider, one quotient bit a cycle
                rem_sh = {rem_reg[CW-1:0], work_reg[63]};
                if (tcnt_reg != '0 && rem_sh >= {1'b0, tcnt_reg}) begin
                    rem_next  = rem_sh - {1'b0, tcnt_reg};
                    work_next = {work_reg[62:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    work_next = {work_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 7'd63) begin
                    if (tcnt_reg == '0) work_next = '0;
                    root_next  = '0;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                // digit-by-digit root; rem_reg unused here, work_reg holds quotient
                sq_trial = {root_reg | (32'd1 << (31 - cnt_reg[4:0])), 32'd0} >> 32;
                mul_a = root_reg | (32'd1 << (31 - cnt_reg[4:0]));
                mul_b = root_reg | (32'd1 << (31 - cnt_reg[4:0]));
                if (mul_p <= work_reg && sq_trial[31:0] != 32'd0)
                    root_next = mul_a;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 7'd31) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (close_reg) begin
                    rms_next  = (root_reg > 32'd32768) ? 16'h8000 : root_reg[15:0];
                    bsum_next = '0;
                    bcnt_next = '0;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = {7'd0, rms_reg, act_reg, gate_reg, peak_reg,
                                   clip_reg, g_reg};
                    muser_next  = close_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            tsum_reg   <= '0;
            tcnt_reg   <= '0;
            bsum_reg   <= '0;
            bcnt_reg   <= '0;
            peak_reg   <= '0;
            clip_reg   <= 1'b0;
            gate_reg   <= 1'b0;
            act_reg    <= '0;
            rms_reg    <= '0;
            mvalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            tsum_reg   <= tsum_next;
            tcnt_reg   <= tcnt_next;
            bsum_reg   <= bsum_next;
            bcnt_reg   <= bcnt_next;
            peak_reg   <= peak_next;
            clip_reg   <= clip_next;
            gate_reg   <= gate_next;
            act_reg    <= act_next;
            rms_reg    <= rms_next;
            mvalid_reg <= mvalid_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        samp_reg  <= samp_next;
        bend_reg  <= bend_next;
        close_reg <= close_next;
        prod_reg  <= prod_next;
        g_reg     <= g_next;
        sq_reg    <= sq_next;
        work_reg  <= work_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        lvl_reg   <= lvl_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks audio_gain_level_meter_gate word by word against an in-bench
// model of the gain, metering and gate logic, with random stalls on both sides
// ----------------------------------------------------------------------------
module testbench;
    import aglmg_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 3000000;
    localparam int unsigned BLK_MAX      = BLOCK_MAX_DEF;

    typedef struct {
        logic [15:0] gained;
        logic        clip;
        logic [14:0] peak;
        logic        gate;
        logic [31:0] active;
        logic [15:0] rms;
        logic        stats;
    } meter_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // sample_in
    logic [1:0]  s_tuser;   // block_end, start_new
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;   // scaled_out, clipped_so_far, peak_level,
                            // gate_open, gated_count, total_rms, pad
    logic        m_tuser;   // stats_valid
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    audio_gain_level_meter_gate dut (.*);

    // model copy of registers and statistics
    int unsigned       gain_r, thr_r, hyst_r;
    longint unsigned   tot_sq, tot_cnt, blk_sq, act_cnt;
    int unsigned       blk_cnt, peak_r, rms_r;
    bit                clip_r, gate_r;

    meter_word_t expected_words[$];
    int unsigned errors = 0;
    longint unsigned cycles = 0;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic void clear_meter();
        tot_sq = 0; tot_cnt = 0; blk_sq = 0; blk_cnt = 0; peak_r = 0;
        clip_r = 0; gate_r = 0; act_cnt = 0; rms_r = 0;
    endfunction

    function automatic meter_word_t meter_step(logic [15:0] smp, bit blk_end, bit start);
        meter_word_t w;
        int g, mag;
        longint unsigned sq, lvl, r, a;
        bit closing, pass;
        if (start) clear_meter();
        g = ($signed(smp) * int'(gain_r)) / 256;
        if (g > 32767) begin
            g = 32767; clip_r = 1;
        end else if (g < -32768) begin
            g = -32768; clip_r = 1;
        end
        sq = longint'(g) * longint'(g);
        mag = (g == -32768) ? 32767 : (g < 0 ? -g : g);
        if (mag > peak_r) peak_r = mag;
        blk_sq += sq;
        blk_cnt++;
        if (tot_cnt < 64'hFFFF_FFFF) begin
            tot_cnt++;
            tot_sq = (tot_sq > ~sq) ? ~64'd0 : tot_sq + sq;
        end
        closing = blk_end || blk_cnt >= BLK_MAX;
        if (closing) begin
            if (thr_r == 0) begin
                pass = 1;
            end else begin
                lvl = gate_r ? ((thr_r > hyst_r) ? thr_r - hyst_r : 0) : thr_r;
                pass = blk_sq >= lvl * lvl * blk_cnt;
            end
            gate_r = pass;
            if (pass) begin
                a = act_cnt + blk_cnt;
                act_cnt = (a > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : a;
            end
            r = (tot_cnt != 0) ? int_sqrt(tot_sq / tot_cnt) : 0;
            rms_r = (r > 32768) ? 32768 : int'(r);
            blk_sq = 0;
            blk_cnt = 0;
        end
        w.gained = g[15:0];
        w.clip = clip_r;
        w.peak = peak_r[14:0];
        w.gate = gate_r;
        w.active = act_cnt[31:0];
        w.rms = rms_r[15:0];
        w.stats = closing;
        return w;
    endfunction

    task automatic send_sample(logic [15:0] smp, bit blk_end, bit start);
        int unsigned gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= smp;
        s_tuser  <= {start, blk_end};
        @(posedge aclk iff (s_tvalid && s_tready));
        expected_words.push_back(meter_step(smp, blk_end, start));
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        drain();
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk iff (psel && penable && pready));
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_GAIN: begin
                gain_r = val[12:0];
                if (gain_r < GAIN_MIN) gain_r = GAIN_MIN;
                if (gain_r > GAIN_MAX) gain_r = GAIN_MAX;
            end
            REG_THR:  thr_r = val[14:0];
            REG_HYST: hyst_r = val[14:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [31:0] g, logic [31:0] t, logic [31:0] h);
        apb_write(REG_GAIN, g);
        apb_write(REG_THR, t);
        apb_write(REG_HYST, h);
    endtask

    always begin
        int unsigned stall;
        meter_word_t w;
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (stall > 0) begin
            m_tready <= 0;
            repeat (stall) @(posedge aclk);
        end
        m_tready <= 1;
        @(posedge aclk iff (m_tvalid && m_tready && aresetn));
        if (expected_words.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
        end else begin
            w = expected_words.pop_front();
            if (m_tdata[15:0] !== w.gained) begin
                $error("scaled_out exp %0d got %0d", $signed(w.gained),
                       $signed(m_tdata[15:0]));
                errors++;
            end
            if (m_tdata[16] !== w.clip) begin
                $error("clipped_so_far exp %0d got %0d", w.clip, m_tdata[16]);
                errors++;
            end
            if (m_tdata[31:17] !== w.peak) begin
                $error("peak_level exp %0d got %0d", w.peak, m_tdata[31:17]);
                errors++;
            end
            if (m_tdata[32] !== w.gate) begin
                $error("gate_open exp %0d got %0d", w.gate, m_tdata[32]);
                errors++;
            end
            if (m_tdata[64:33] !== w.active) begin
                $error("gated_count exp %0d got %0d", w.active, m_tdata[64:33]);
                errors++;
            end
            if (m_tdata[80:65] !== w.rms) begin
                $error("total_rms exp %0d got %0d", w.rms, m_tdata[80:65]);
                errors++;
            end
            if (m_tuser !== w.stats) begin
                $error("stats_valid exp %0d got %0d", w.stats, m_tuser);
                errors++;
            end
        end
    end

    function automatic logic [15:0] rand_sample(int unsigned shift);
        logic [15:0] v;
        v = 16'($urandom);
        return 16'($signed(v) >>> shift);
    endfunction

    task automatic send_block(int unsigned len, bit start, bit noisy);
        int unsigned shift;
        shift = $urandom_range(0, 15);
        for (int unsigned i = 0; i < len; i++) begin
            if (noisy)
                send_sample(16'($urandom), 1'($urandom_range(0, 1)),
                            $urandom_range(0, 9) == 0);
            else
                send_sample(rand_sample(shift), i == len - 1, start && i == 0);
        end
    endtask

    task automatic test_directed();
        send_sample(16'h7FFF, 1'b0, 1'b1);
        send_sample(16'h8000, 1'b0, 1'b0);
        send_sample(16'h0000, 1'b0, 1'b0);
        send_sample(16'hFFFF, 1'b1, 1'b0);
        send_sample(16'h0001, 1'b1, 1'b0);
        send_sample(16'h0000, 1'b1, 1'b1);
        set_regs(0, 0, 0);
        send_sample(16'h0003, 1'b0, 1'b0);
        send_sample(16'hFFFD, 1'b0, 1'b0);
        send_sample(16'h8000, 1'b0, 1'b0);
        send_sample(16'h7FFF, 1'b1, 1'b0);
        set_regs(32'hFFFF_FFFF, 0, 0);
        send_sample(16'h8000, 1'b0, 1'b1);
        send_sample(16'h0008, 1'b1, 1'b0);
        set_regs(256, 100, 50);
        send_sample(16'd200, 1'b1, 1'b1);
        send_sample(16'd80, 1'b1, 1'b0);
        send_sample(16'd20, 1'b1, 1'b0);
        send_sample(16'd40, 1'b1, 1'b0);
        send_sample(16'd120, 1'b1, 1'b0);
    endtask

    task automatic test_gate_hysteresis();
        set_regs(256, 32767, 32767);
        send_block(5, 1'b1, 1'b0);
        send_sample(16'h8000, 1'b1, 1'b0);
        send_sample(16'h0000, 1'b1, 1'b0);
        set_regs(4096, 32767, 0);
        send_block(8, 1'b0, 1'b0);
        send_sample(16'h8000, 1'b1, 1'b0);
    endtask

    task automatic test_overlong_block();
        set_regs(300, 1000, 400);
        for (int unsigned i = 0; i < BLK_MAX + 5; i++)
            send_sample(rand_sample($urandom_range(4, 15)), 1'b0, i == 0);
        send_sample(16'h1234, 1'b1, 1'b0);
    endtask

    task automatic test_random();
        int unsigned len;
        logic [31:0] gains[6] = '{0, 64, 4096, 8191, 256, 1024};
        for (int ph = 0; ph < 8; ph++) begin
            set_regs(ph < 6 ? gains[ph] : $urandom_range(0, 8191),
                     ph == 1 ? 0 : $urandom_range(0, 3000),
                     ph == 7 ? 32767 : $urandom_range(0, 2000));
            for (int unsigned n = 0; n < 24; n += len) begin
                len = $urandom_range(1, 12);
                send_block(len, $urandom_range(0, 14) == 0, $urandom_range(0, 9) == 0);
                if (ph == 3 && n == 0) drain();
            end
        end
    endtask

    initial begin
        gain_r = GAIN_RESET; thr_r = 0; hyst_r = 0;
        clear_meter();
        aresetn = 0; s_tvalid = 0; s_tdata = 0; s_tuser = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_directed();
        test_gate_hysteresis();
        test_overlong_block();
        test_random();
        s_tvalid <= 0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
design/aglmg_pkg.sv
design/audio_gain_level_meter_gate.sv
verif/testbench.sv
